// ===== src/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, constants and the CRC-16 byte update for the response frame
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

  localparam logic [15:0] CrcStart = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  FuncCode = 8'h03;
  localparam logic [7:0]  LenCode  = 8'h04;

  localparam logic [2:0]  PosFunc  = 3'd0;
  localparam logic [2:0]  PosLen   = 3'd1;
  localparam logic [2:0]  PosCrcLo = 3'd6;
  localparam logic [2:0]  PosLast  = 3'd7;

  localparam logic [1:0]  StatOk     = 2'd0;
  localparam logic [1:0]  StatHeader = 2'd1;
  localparam logic [1:0]  StatCrc    = 2'd2;

  // one received word held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } srfc_word_t;

  // reflected CRC-16 update by one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/srfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// srfc_in_reg
// Input register: captures one received word and holds it until the frame
// logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               take_i,
  output srfc_pkg::srfc_word_t word_o
);
  import srfc_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

`default_nettype wire

// ===== src/srfc_frame.sv =====
// ----------------------------------------------------------------------------
// srfc_frame
// Frame state (position, CRC, payload, header check) and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srfc_pkg::srfc_word_t word_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          reading_o,
  output logic [1:0]           status_o
);
  import srfc_pkg::*;

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [31:0] shift_q, shift_d;
  logic        hdr_q, hdr_d;
  logic [7:0]  lowb_q, lowb_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] reading_q, reading_d;
  logic [1:0]  status_q, status_d;
  logic        out_free;
  logic        last;
  logic [15:0] got;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign last     = (pos_q == PosLast);
  assign take_o   = word_i.valid & (~last | out_free);
  assign got      = {word_i.data, lowb_q};

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    shift_d     = shift_q;
    hdr_d       = hdr_q;
    lowb_d      = lowb_q;
    reading_d   = reading_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (take_o) begin
      if (pos_q < PosCrcLo) begin
        crc_d = crc_feed(crc_q, word_i.data);
      end
      if ((pos_q == PosFunc && word_i.data != FuncCode) ||
          (pos_q == PosLen && word_i.data != LenCode)) begin
        hdr_d = 1'b0;
      end
      if (pos_q inside {[3'd2:3'd5]}) begin
        shift_d = {shift_q[23:0], word_i.data};
      end
      if (pos_q == PosCrcLo) begin
        lowb_d = word_i.data;
      end
      if (last) begin
        if (!hdr_q) begin
          status_d = StatHeader;
        end else if (got != crc_q) begin
          status_d = StatCrc;
        end else begin
          status_d = StatOk;
        end
        reading_d   = (hdr_q && got == crc_q) ? shift_q : 32'd0;
        out_valid_d = 1'b1;
        pos_d       = 3'd0;
        crc_d       = CrcStart;
        shift_d     = 32'd0;
        hdr_d       = 1'b1;
        lowb_d      = 8'd0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      crc_q       <= CrcStart;
      shift_q     <= 32'd0;
      hdr_q       <= 1'b1;
      lowb_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      shift_q     <= shift_d;
      hdr_q       <= hdr_d;
      lowb_q      <= lowb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reading_q <= reading_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign reading_o   = reading_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== src/sensor_response_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// sensor_response_frame_checker_core
// Checks an eight-word sensor read response: header, CRC-16 and reading.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o | data_byte_i
//   out     | source    | out_valid_o/out_stall_i | reading_o, status_o
//
// One word per cycle sustained while the result is not stalled; input register then frame
// logic and result register, so a result is registered after its last word leaves the input register.
// Reset returns the frame position, CRC and header flag to their start values; no clearing pass.
// A stalled result holds only the next frame's last word in the input
// register; the input stalls while that word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_response_frame_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] reading_o,
  output logic [1:0]  status_o
);
  import srfc_pkg::*;

  srfc_word_t word;
  logic       take;

  srfc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .take_i      (take),
    .word_o      (word)
  );

  srfc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .reading_o   (reading_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire
